@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk_i outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

@@ rtl/pp422_pkg.sv @@
// types, constants and register map of the planar 4:2:0 to packed 4:2:2 converter
package pp422_pkg;

  localparam int unsigned MAX_PAIRS_DEF     = 1024;
  localparam int unsigned MAX_ROW_PAIRS_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam int OFFSET_W         = 26;
  localparam int PAIR_COUNT_W     = 11;
  localparam int ROW_PAIR_COUNT_W = 12;
  localparam int PITCH_W          = 15;
  localparam int ADDR_W           = 5;
  localparam int DATA_W           = 32;

  typedef enum logic [2:0] {
    REG_OUTPUT_ORDER   = 3'd0,
    REG_SOURCE_PLANAR  = 3'd1,
    REG_PAIR_COUNT     = 3'd2,
    REG_ROW_PAIR_COUNT = 3'd3,
    REG_LINE_PITCH     = 3'd4,
    REG_VERTICAL_FLIP  = 3'd5
  } reg_idx_e;

  localparam logic                        RST_OUTPUT_ORDER   = 1'b0;
  localparam logic                        RST_SOURCE_PLANAR  = 1'b1;
  localparam logic [PAIR_COUNT_W-1:0]     RST_PAIR_COUNT     = 11'd320;
  localparam logic [ROW_PAIR_COUNT_W-1:0] RST_ROW_PAIR_COUNT = 12'd240;
  localparam logic [PITCH_W-1:0]          RST_LINE_PITCH     = 15'd2560;
  localparam logic                        RST_VERTICAL_FLIP  = 1'b0;

  typedef struct packed {
    logic                        output_order;
    logic                        source_planar;
    logic [PAIR_COUNT_W-1:0]     pair_count;
    logic [ROW_PAIR_COUNT_W-1:0] row_pair_count;
    logic [PITCH_W-1:0]          line_pitch;
    logic                        vertical_flip;
  } cfg_t;

  // what the back end does with the chroma of a word
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_STORE,
    KIND_REUSE
  } kind_e;

  typedef struct packed {
    logic [7:0]          luma_first;
    logic [7:0]          luma_second;
    logic [7:0]          chroma_u;
    logic [7:0]          chroma_v;
    kind_e               kind;
    logic [OFFSET_W-1:0] out_row;
    logic                frame_end;
  } pix_t;

endpackage

@@ rtl/pp422_regs.sv @@
// apb configuration registers
module pp422_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pp422_pkg::ADDR_W-1:0]   paddr,
  input  logic [pp422_pkg::DATA_W-1:0]   pwdata,
  output logic [pp422_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output pp422_pkg::cfg_t                cfg_o
);
  import pp422_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_OUTPUT_ORDER:   cfg_d.output_order   = pwdata[0];
        REG_SOURCE_PLANAR:  cfg_d.source_planar  = pwdata[0];
        REG_PAIR_COUNT:     cfg_d.pair_count     = pwdata[PAIR_COUNT_W-1:0];
        REG_ROW_PAIR_COUNT: cfg_d.row_pair_count = pwdata[ROW_PAIR_COUNT_W-1:0];
        REG_LINE_PITCH:     cfg_d.line_pitch     = pwdata[PITCH_W-1:0];
        REG_VERTICAL_FLIP:  cfg_d.vertical_flip  = pwdata[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OUTPUT_ORDER:   prdata = DATA_W'(cfg_q.output_order);
      REG_SOURCE_PLANAR:  prdata = DATA_W'(cfg_q.source_planar);
      REG_PAIR_COUNT:     prdata = DATA_W'(cfg_q.pair_count);
      REG_ROW_PAIR_COUNT: prdata = DATA_W'(cfg_q.row_pair_count);
      REG_LINE_PITCH:     prdata = DATA_W'(cfg_q.line_pitch);
      REG_VERTICAL_FLIP:  prdata = DATA_W'(cfg_q.vertical_flip);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_order   <= RST_OUTPUT_ORDER;
      cfg_q.source_planar  <= RST_SOURCE_PLANAR;
      cfg_q.pair_count     <= RST_PAIR_COUNT;
      cfg_q.row_pair_count <= RST_ROW_PAIR_COUNT;
      cfg_q.line_pitch     <= RST_LINE_PITCH;
      cfg_q.vertical_flip  <= RST_VERTICAL_FLIP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/pp422_front.sv @@
// front end: takes pixel pairs, tracks column and row, classifies chroma use
`include "assert_macros.svh"

module pp422_front #(
  parameter int unsigned MAX_PAIRS     = pp422_pkg::MAX_PAIRS_DEF,
  parameter int unsigned MAX_ROW_PAIRS = pp422_pkg::MAX_ROW_PAIRS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pp422_pkg::cfg_t                cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     luma_first_i,
  input  logic [7:0]                     luma_second_i,
  input  logic [7:0]                     chroma_u_i,
  input  logic [7:0]                     chroma_v_i,
  input  logic                           full_i,
  output logic                           push_o,
  output pp422_pkg::pix_t                item_o,
  output logic [$clog2(MAX_PAIRS)-1:0]   col_o
);
  import pp422_pkg::*;

  localparam int CW  = $clog2(MAX_PAIRS);
  localparam int PCW = $clog2(MAX_PAIRS + 1);
  localparam int RW  = $clog2(2 * MAX_ROW_PAIRS);
  localparam int RCW = $clog2(MAX_ROW_PAIRS + 1);
  localparam int RSW = RCW + 1;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [PCW-1:0] eff_pairs;
  logic [RCW-1:0] eff_row_pairs;
  logic [RSW-1:0] rows;
  logic           row_done;
  logic           frame_done;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    if (cfg_i.pair_count == '0) begin
      eff_pairs = PCW'(1);
    end else if (32'(cfg_i.pair_count) > MAX_PAIRS) begin
      eff_pairs = PCW'(MAX_PAIRS);
    end else begin
      eff_pairs = PCW'(cfg_i.pair_count);
    end
    if (cfg_i.row_pair_count == '0) begin
      eff_row_pairs = RCW'(1);
    end else if (32'(cfg_i.row_pair_count) > MAX_ROW_PAIRS) begin
      eff_row_pairs = RCW'(MAX_ROW_PAIRS);
    end else begin
      eff_row_pairs = RCW'(cfg_i.row_pair_count);
    end
  end

  assign rows       = {eff_row_pairs, 1'b0};
  assign row_done   = (PCW'(col_q) + PCW'(1)) >= eff_pairs;
  assign frame_done = row_done && ((RSW'(row_q) + RSW'(1)) >= rows);

  always_comb begin
    item_o.luma_first  = luma_first_i;
    item_o.luma_second = luma_second_i;
    item_o.chroma_u    = chroma_u_i;
    item_o.chroma_v    = chroma_v_i;
    item_o.frame_end   = frame_done;
    if (!cfg_i.source_planar) begin
      item_o.kind = KIND_PASS;
    end else if (!row_q[0]) begin
      item_o.kind = KIND_STORE;
    end else begin
      item_o.kind = KIND_REUSE;
    end
    // flipped row wraps like the offset does
    if (cfg_i.vertical_flip) begin
      item_o.out_row = OFFSET_W'(rows) - OFFSET_W'(1) - OFFSET_W'(row_q);
    end else begin
      item_o.out_row = OFFSET_W'(row_q);
    end
  end

  assign col_o = col_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (!row_done) begin
        col_d = col_q + CW'(1);
      end else begin
        col_d = '0;
        row_d = frame_done ? '0 : row_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `ASSERT_AT(a_front_frame_wrap, push_o && item_o.frame_end |=> col_q == '0 && row_q == '0, "counters not cleared after frame end")

endmodule

@@ rtl/pp422_fifo.sv @@
// short word queue between front and back end
`include "assert_macros.svh"

module pp422_fifo #(
  parameter int unsigned DEPTH = pp422_pkg::QUEUE_DEPTH,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_fifo_underflow, pop_i && empty_o, "pop from empty queue")

endmodule

@@ rtl/pp422_back.sv @@
// back end: chroma line store, row offset multiply, packing and output register
`include "assert_macros.svh"

module pp422_back #(
  parameter int unsigned MAX_PAIRS = pp422_pkg::MAX_PAIRS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pp422_pkg::cfg_t                     cfg_i,
  input  logic                                q_valid_i,
  output logic                                q_pop_o,
  input  pp422_pkg::pix_t                     item_i,
  input  logic [$clog2(MAX_PAIRS)-1:0]        col_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [31:0]                         packed_word_o,
  output logic [pp422_pkg::OFFSET_W-1:0]      byte_offset_o,
  output logic                                frame_end_o
);
  import pp422_pkg::*;

  localparam int CW     = $clog2(MAX_PAIRS);
  localparam int PROD_W = OFFSET_W + PITCH_W;

  logic [15:0]         store_q [MAX_PAIRS];
  logic [15:0]         store_rd_q;
  logic                advance;
  logic                va_q, ov_q;
  pix_t                item_a_q;
  logic [CW-1:0]       col_a_q;
  logic [PROD_W-1:0]   prod;
  logic [OFFSET_W-1:0] base_q;
  logic [7:0]          u_sel, v_sel;
  logic [31:0]         word_d, word_q;
  logic [OFFSET_W-1:0] off_d, off_q;
  logic                fe_q;

  assign advance = !ov_q || !out_stall_i;
  assign q_pop_o = advance && q_valid_i;
  assign prod    = PROD_W'(item_i.out_row) * PROD_W'(cfg_i.line_pitch);

  // single port line store, registered read
  always_ff @(posedge clk_i) begin
    if (advance) begin
      store_rd_q <= store_q[col_i];
      if (q_valid_i && item_i.kind == KIND_STORE) begin
        store_q[col_i] <= {item_i.chroma_v, item_i.chroma_u};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      item_a_q <= item_i;
      col_a_q  <= col_i;
      base_q   <= prod[OFFSET_W-1:0];
      word_q   <= word_d;
      off_q    <= off_d;
      fe_q     <= item_a_q.frame_end;
    end
  end

  always_comb begin
    if (item_a_q.kind == KIND_REUSE) begin
      u_sel = store_rd_q[7:0];
      v_sel = store_rd_q[15:8];
    end else begin
      u_sel = item_a_q.chroma_u;
      v_sel = item_a_q.chroma_v;
    end
    if (cfg_i.output_order) begin
      word_d = {item_a_q.luma_second, v_sel, item_a_q.luma_first, u_sel};
    end else begin
      word_d = {v_sel, item_a_q.luma_second, u_sel, item_a_q.luma_first};
    end
    off_d = base_q + OFFSET_W'({col_a_q, 2'b00});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (advance) begin
      va_q <= q_valid_i;
      ov_q <= va_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign packed_word_o = word_q;
  assign byte_offset_o = off_q;
  assign frame_end_o   = fe_q;

  `ASSERT_AT(a_back_hold, va_q && ov_q && out_stall_i |=> va_q && ov_q, "back pipeline lost a word under stall")

endmodule

@@ rtl/planar_420_to_packed_422.sv @@
// top level of the planar 4:2:0 to packed 4:2:2 pixel pair converter
// Takes one pixel pair per clock and gives one packed YUY2 or UYVY word with
// its byte offset per pair, sustained at one word per clock while the output
// side does not stall. A word passes through the four-entry queue, then a
// back end stage that reads the single-port chroma line store and multiplies
// row by pitch, then the output register. The queue lets the input keep
// going for four words while the output stalls. The line store (MAX_PAIRS x
// 16 bits) needs no clearing pass; an odd planar row must only read columns
// that the even row above wrote.
module planar_420_to_packed_422 #(
  parameter int unsigned MAX_PAIRS     = pp422_pkg::MAX_PAIRS_DEF,
  parameter int unsigned MAX_ROW_PAIRS = pp422_pkg::MAX_ROW_PAIRS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pp422_pkg::ADDR_W-1:0]        paddr,
  input  logic [pp422_pkg::DATA_W-1:0]        pwdata,
  output logic [pp422_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          luma_first_i,
  input  logic [7:0]                          luma_second_i,
  input  logic [7:0]                          chroma_u_i,
  input  logic [7:0]                          chroma_v_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [31:0]                         packed_word_o,
  output logic [pp422_pkg::OFFSET_W-1:0]      byte_offset_o,
  output logic                                frame_end_o
);
  import pp422_pkg::*;

  localparam int CW = $clog2(MAX_PAIRS);
  localparam int QW = CW + $bits(pix_t);

  cfg_t          cfg;
  logic          push, pop, full, empty;
  pix_t          item_f, item_b;
  logic [CW-1:0] col_f, col_b;
  logic [QW-1:0] q_out;

  pp422_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pp422_front #(
    .MAX_PAIRS     (MAX_PAIRS),
    .MAX_ROW_PAIRS (MAX_ROW_PAIRS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .luma_first_i  (luma_first_i),
    .luma_second_i (luma_second_i),
    .chroma_u_i    (chroma_u_i),
    .chroma_v_i    (chroma_v_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (item_f),
    .col_o         (col_f)
  );

  pp422_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({col_f, item_f}),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign col_b  = q_out[QW-1:$bits(pix_t)];
  assign item_b = pix_t'(q_out[$bits(pix_t)-1:0]);

  pp422_back #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (!empty),
    .q_pop_o       (pop),
    .item_i        (item_b),
    .col_i         (col_b),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_word_o (packed_word_o),
    .byte_offset_o (byte_offset_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

@@ tb/sv/pp422_checker.sv @@
// checker that predicts each packed word, its byte offset and the frame end, and compares
`timescale 1ns / 100ps
module pp422_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pp422_pkg::ADDR_W-1:0]   paddr,
  input  logic [pp422_pkg::DATA_W-1:0]   pwdata,
  input  logic                           pready,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic [7:0]                     luma_first_i,
  input  logic [7:0]                     luma_second_i,
  input  logic [7:0]                     chroma_u_i,
  input  logic [7:0]                     chroma_v_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [31:0]                    packed_word_o,
  input  logic [pp422_pkg::OFFSET_W-1:0] byte_offset_o,
  input  logic                           frame_end_o,
  output int                             mismatch_count_o,
  output int                             words_pending_o
);
  import pp422_pkg::*;

  typedef struct packed {
    logic [31:0]         word;
    logic [OFFSET_W-1:0] offset;
    logic                frame_end;
  } placed_word_t;

  cfg_t                        cfg;
  int unsigned                 column;
  logic [ROW_PAIR_COUNT_W-1:0] row;
  logic [15:0]                 chroma_row [MAX_PAIRS_DEF];
  placed_word_t                expected_words [$];
  placed_word_t                front_word;

  function automatic placed_word_t place_pair(input logic [7:0] y0, y1, u_in, v_in);
    int unsigned  pairs;
    int unsigned  rows;
    int unsigned  slot;
    int unsigned  out_row;
    int unsigned  base;
    logic [7:0]   u;
    logic [7:0]   v;
    logic         row_done;
    logic         frame_done;
    placed_word_t pw;
    if (cfg.pair_count == '0) pairs = 1;
    else if (cfg.pair_count > MAX_PAIRS_DEF) pairs = MAX_PAIRS_DEF;
    else pairs = cfg.pair_count;
    if (cfg.row_pair_count == '0) rows = 2;
    else if (cfg.row_pair_count > MAX_ROW_PAIRS_DEF) rows = 2 * MAX_ROW_PAIRS_DEF;
    else rows = 2 * cfg.row_pair_count;
    slot = (column < MAX_PAIRS_DEF) ? column : MAX_PAIRS_DEF - 1;
    u = u_in;
    v = v_in;
    // even planar rows fill the line store, odd rows reuse it
    if (cfg.source_planar) begin
      if (!row[0]) chroma_row[slot] = {v_in, u_in};
      else {v, u} = chroma_row[slot];
    end
    pw.word = cfg.output_order ? {y1, v, y0, u} : {v, y1, u, y0};
    out_row = cfg.vertical_flip ? rows - 1 - row : row;
    base = out_row * cfg.line_pitch;
    pw.offset = base + column * 4;
    row_done = (column + 1 >= pairs);
    frame_done = row_done && (row + 1 >= rows);
    pw.frame_end = frame_done;
    if (!row_done) begin
      column = column + 1;
    end else begin
      column = 0;
      row = frame_done ? '0 : row + 1'b1;
    end
    return pw;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.output_order   = RST_OUTPUT_ORDER;
      cfg.source_planar  = RST_SOURCE_PLANAR;
      cfg.pair_count     = RST_PAIR_COUNT;
      cfg.row_pair_count = RST_ROW_PAIR_COUNT;
      cfg.line_pitch     = RST_LINE_PITCH;
      cfg.vertical_flip  = RST_VERTICAL_FLIP;
      column = 0;
      row = '0;
      expected_words.delete();
      mismatch_count_o = 0;
      words_pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_OUTPUT_ORDER:   cfg.output_order   = pwdata[0];
          REG_SOURCE_PLANAR:  cfg.source_planar  = pwdata[0];
          REG_PAIR_COUNT:     cfg.pair_count     = pwdata[PAIR_COUNT_W-1:0];
          REG_ROW_PAIR_COUNT: cfg.row_pair_count = pwdata[ROW_PAIR_COUNT_W-1:0];
          REG_LINE_PITCH:     cfg.line_pitch     = pwdata[PITCH_W-1:0];
          REG_VERTICAL_FLIP:  cfg.vertical_flip  = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(place_pair(luma_first_i, luma_second_i, chroma_u_i,
                                            chroma_v_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("mismatch at %0t: word %08h offset %07h end %0b with no word expected",
                     $time, packed_word_o, byte_offset_o, frame_end_o);
          end
          mismatch_count_o++;
        end else begin
          front_word = expected_words.pop_front();
          if (front_word.word !== packed_word_o || front_word.offset !== byte_offset_o ||
              front_word.frame_end !== frame_end_o) begin
            if (mismatch_count_o < 10) begin
              $display("mismatch at %0t: word exp %08h got %08h, offset exp %07h got %07h, %s",
                       $time, front_word.word, packed_word_o, front_word.offset,
                       byte_offset_o, "frame end follows");
              $display("  frame end exp %0b got %0b", front_word.frame_end, frame_end_o);
            end
            mismatch_count_o++;
          end
        end
      end
      words_pending_o = expected_words.size();
    end
  end

endmodule

@@ tb/sv/tb_planar_420_to_packed_422.sv @@
// testbench top: drives pixel pairs and register writes into the converter and gives the verdict
`timescale 1ns / 100ps
module tb_planar_420_to_packed_422;
  import pp422_pkg::*;

  localparam int     FILL_PAIRS   = MAX_PAIRS_DEF;
  localparam int     RANDOM_PAIRS = 60;
  localparam int     HOLD_AT_WORD = 100;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 8;
  localparam longint RUN_LIMIT_NS = 10_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          luma_first_i;
  logic [7:0]          luma_second_i;
  logic [7:0]          chroma_u_i;
  logic [7:0]          chroma_v_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [31:0]         packed_word_o;
  logic [OFFSET_W-1:0] byte_offset_o;
  logic                frame_end_o;

  int mismatch_count;
  int words_pending;
  int recv_words;
  bit send_burst;
  bit recv_burst;

  planar_420_to_packed_422 uut (.*);

  pp422_checker word_checker (
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending),
    .*
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    logic [DATA_W-1:0] field_mask;
    case (idx)
      REG_PAIR_COUNT:     field_mask = (32'd1 << PAIR_COUNT_W) - 1;
      REG_ROW_PAIR_COUNT: field_mask = (32'd1 << ROW_PAIR_COUNT_W) - 1;
      REG_LINE_PITCH:     field_mask = (32'd1 << PITCH_W) - 1;
      default:            field_mask = 32'd1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & field_mask) | ($urandom_range(0, 1) ? ($urandom() & ~field_mask) : '0);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pair(input logic [7:0] y0, y1, u, v);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    luma_first_i  <= y0;
    luma_second_i <= y1;
    chroma_u_i    <= u;
    chroma_v_i    <= v;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (words_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic shuffle_config();
    int unsigned value;
    if ($urandom_range(0, 1)) write_reg(REG_OUTPUT_ORDER, $urandom_range(0, 1));
    if ($urandom_range(0, 1)) write_reg(REG_SOURCE_PLANAR, $urandom_range(0, 1));
    if ($urandom_range(0, 1)) write_reg(REG_VERTICAL_FLIP, $urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0: value = 0;
        1: value = 1;
        2: value = MAX_PAIRS_DEF;
        3: value = 2047;
        4: value = $urandom_range(MAX_PAIRS_DEF + 1, 2047);
        default: value = $urandom_range(2, 12);
      endcase
      write_reg(REG_PAIR_COUNT, value);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0: value = 0;
        1: value = 1;
        2: value = MAX_ROW_PAIRS_DEF;
        3: value = 4095;
        4: value = $urandom_range(MAX_ROW_PAIRS_DEF + 1, 4095);
        default: value = $urandom_range(1, 3);
      endcase
      write_reg(REG_ROW_PAIR_COUNT, value);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0: value = $urandom_range(0, 3);
        1: value = 4;
        2: value = 16384;
        3: value = 32767;
        4: value = $urandom_range(0, 32767);
        default: value = $urandom_range(1, 64) * 4;
      endcase
      write_reg(REG_LINE_PITCH, value);
    end
  endtask

  initial begin
    int random_sent;
    int phase_len;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    luma_first_i  = '0;
    luma_second_i = '0;
    chroma_u_i    = '0;
    chroma_v_i    = '0;
    send_burst    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one full-width even row so that every line store entry holds chroma
    write_reg(REG_PAIR_COUNT, FILL_PAIRS);
    write_reg(REG_ROW_PAIR_COUNT, 1);
    write_reg(REG_LINE_PITCH, 16384);
    repeat (FILL_PAIRS) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain();

    // odd row chroma reuse, uyvy order, flipped rows, smallest legal pitch
    write_reg(REG_OUTPUT_ORDER, 1);
    write_reg(REG_PAIR_COUNT, 2);
    write_reg(REG_VERTICAL_FLIP, 1);
    write_reg(REG_LINE_PITCH, 4);
    send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pair(8'h00, 8'h00, 8'h00, 8'h00);
    send_pair(8'hA5, 8'h5A, 8'hC3, 8'h3C);
    send_pair(8'h01, 8'h80, 8'h7F, 8'hFE);
    send_pair(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00, 8'hFF, 8'h00);
    drain();

    // packed source, zero counts and zero pitch
    write_reg(REG_SOURCE_PLANAR, 0);
    write_reg(REG_OUTPUT_ORDER, 0);
    write_reg(REG_PAIR_COUNT, 0);
    write_reg(REG_ROW_PAIR_COUNT, 0);
    write_reg(REG_LINE_PITCH, 0);
    write_reg(REG_VERTICAL_FLIP, 0);
    send_pair(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_pair(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_pair(8'h55, 8'hAA, 8'h33, 8'hCC);
    send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain();

    // counts above the maximum, largest pitch, flipped offsets that wrap
    write_reg(REG_SOURCE_PLANAR, 1);
    write_reg(REG_OUTPUT_ORDER, 1);
    write_reg(REG_PAIR_COUNT, 2047);
    write_reg(REG_ROW_PAIR_COUNT, 4095);
    write_reg(REG_LINE_PITCH, 32767);
    write_reg(REG_VERTICAL_FLIP, 1);
    repeat (4) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain();

    // counts lowered in the middle of a row
    write_reg(REG_PAIR_COUNT, 2);
    write_reg(REG_ROW_PAIR_COUNT, 1);
    repeat (3) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain();

    // row index left beyond a lowered frame height while flipped
    write_reg(REG_PAIR_COUNT, 1);
    write_reg(REG_ROW_PAIR_COUNT, 8);
    write_reg(REG_VERTICAL_FLIP, 0);
    write_reg(REG_LINE_PITCH, 16384);
    repeat (6) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain();
    write_reg(REG_ROW_PAIR_COUNT, 2);
    write_reg(REG_PAIR_COUNT, 3);
    write_reg(REG_VERTICAL_FLIP, 1);
    repeat (3) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain();

    random_sent = 0;
    while (random_sent < RANDOM_PAIRS) begin
      phase_len = $urandom_range(4, 16);
      shuffle_config();
      repeat (phase_len) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      random_sent += phase_len;
      drain();
    end

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int gap;
    out_stall_i = 1'b1;
    recv_words  = 0;
    recv_burst  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 8);
      // long hold-off so the queue fills and the input stalls
      if (recv_words == HOLD_AT_WORD) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      recv_words++;
      @(negedge clk_i);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
